>>> hw/rtl/gds_pkg.sv
package gds_pkg;

  localparam int LineWidth  = 1024;
  localparam int MaxRadius  = 32;
  localparam int MaxHeight  = 4096;
  localparam int FracBits   = 4;
  localparam int RingRows   = 64;
  localparam int RingWords  = LineWidth / 64;
  localparam int XW         = 10;
  localparam int YW         = 12;
  localparam int RW         = 10;
  localparam int SlotW      = 6;
  localparam int BankAw     = SlotW + 3;
  localparam int QW         = 11;
  localparam int DxW        = 6;

  localparam logic [RW-1:0] RadiusSat = RW'(MaxRadius << FracBits);

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MASKR  = 2'd2,
    REG_MASKEN = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BankAw-1:0] ra0;
    logic [BankAw-1:0] ra1;
    logic [BankAw-1:0] wa;
    logic [63:0]       wd;
    logic [1:0]        we;
  } gds_ring_req_t;

  // largest dx in 0..MaxRadius with dx*dx <= q
  function automatic logic [DxW-1:0] dx_limit(input logic [QW-1:0] q);
    logic [DxW-1:0] n;
    n = '0;
    for (int k = 1; k <= MaxRadius; k++) begin
      if (QW'(k * k) <= q) n = DxW'(k);
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/gds_ring.sv
module gds_ring
  import gds_pkg::*;
(
  input  logic          clk,
  input  gds_ring_req_t req,
  output logic [63:0]   q0,
  output logic [63:0]   q1
);

  // even words in bank0, odd words in bank1
  logic [63:0] bank0 [2**BankAw];
  logic [63:0] bank1 [2**BankAw];

  always_ff @(posedge clk) begin
    if (req.we[0]) bank0[req.wa] <= req.wd;
    q0 <= bank0[req.ra0];
  end

  always_ff @(posedge clk) begin
    if (req.we[1]) bank1[req.wa] <= req.wd;
    q1 <= bank1[req.ra1];
  end

endmodule

>>> hw/rtl/greedy_disk_sampler.sv
// channel  | direction | transfer when            | payload
// in_      | slave     | in_tvalid & in_tready    | tdata: radius; tuser: background
// out_     | master    | out_tvalid & out_tready  | tdata: pos_x, pos_y; tuser: accepted
// cfg_     | slave     | cfg_valid & cfg_ready    | cfg_index, cfg_data
// One pixel at a time: idle takes it, then prep; on column 0 its ring row is cleared;
// scan reads up to 33 ring rows (two bank words per cycle), then drains and decides;
// an accepted pixel's word is read, then write-back hands off once output is free.
// rst_n is synchronous; ring contents are not reset, each ring row is zeroed
// when its first pixel arrives. A result held in the output register does not
// block the next transfer in; completion waits only while that register is full.
module greedy_disk_sampler
  import gds_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] radius
  input  logic        in_tuser,   // background
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] pos_x, [21:10] pos_y
  output logic        out_tuser,  // accepted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_CLR  = 6'b000100,
    S_SCAN = 6'b001000,
    S_WRD  = 6'b010000,
    S_WWR  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [10:0]    width_r;
  logic [12:0]    height_r;
  logic [RW-1:0]  maskr_r;
  logic           masken_r;

  logic [XW-1:0]  col_r, col_nxt;
  logic [YW-1:0]  row_r, row_nxt;
  logic [XW-1:0]  x_r, x_nxt;
  logic [YW-1:0]  y_r, y_nxt;
  logic [RW-1:0]  r_r, r_nxt;
  logic [QW-1:0]  q_r, q_nxt;
  logic [10:0]    lim_r, lim_nxt;
  logic [6:0]     sh_r, sh_nxt;
  logic           sel_r, sel_nxt;
  logic [2:0]     a0_r, a0_nxt, a1_r, a1_nxt;
  logic [2:0]     clr_r, clr_nxt;
  logic [DxW-1:0] dy_r, dy_nxt;
  logic           ev_r, ev_nxt;
  logic [DxW-1:0] evdx_r, evdx_nxt;
  logic           hit_r, hit_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           acc_r, acc_nxt;
  logic           oacc_r, oacc_nxt;
  logic [XW-1:0]  ox_r, ox_nxt;
  logic [YW-1:0]  oy_r, oy_nxt;

  gds_ring_req_t  req;
  logic [63:0]    q0, q1;

  gds_ring u_ring (
    .clk (clk),
    .req (req),
    .q0  (q0),
    .q1  (q1)
  );

  logic [10:0] effw;
  logic [12:0] effh;
  always_comb begin
    effw = width_r;
    if (effw == '0) effw = 11'd1;
    if (effw > 11'(LineWidth)) effw = 11'(LineWidth);
    effh = height_r;
    if (effh == '0) effh = 13'd1;
    if (effh > 13'(MaxHeight)) effh = 13'(MaxHeight);
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 13'd1024;
      maskr_r  <= 10'd512;
      masken_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        8'(REG_WIDTH):  width_r  <= cfg_data[10:0];
        8'(REG_HEIGHT): height_r <= cfg_data[12:0];
        8'(REG_MASKR):  maskr_r  <= cfg_data[RW-1:0];
        8'(REG_MASKEN): masken_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // window of 65 bits centered on x
  logic [191:0] cat, shd;
  logic [64:0]  win, keep;
  logic [63:0]  lo, hi;
  always_comb begin
    lo   = sel_r ? q1 : q0;
    hi   = sel_r ? q0 : q1;
    cat  = {hi, lo, 64'b0};
    shd  = cat >> sh_r;
    win  = shd[64:0];
    for (int j = 0; j <= 64; j++) begin
      keep[j] = (7'(j) + 7'(evdx_r) >= 7'd32) && (7'(j) <= 7'd32 + 7'(evdx_r))
                && ((j < 32) || (11'(j - 32) < lim_r));
    end
  end

  logic           accept;
  logic [XW-1:0]  ax;
  logic [YW-1:0]  ay;
  logic [12:0]    ay1;
  logic [RW-1:0]  ar;
  logic [3:0]     wl;
  logic [4:0]     wl1;
  logic [11:0]    dysq;
  logic [YW-1:0]  srow;
  logic           issue_ok;
  logic [YW:0]    ny;
  logic [XW:0]    nx;
  logic [63:0]    wword;

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    r_nxt         = r_r;
    q_nxt         = q_r;
    lim_nxt       = lim_r;
    sh_nxt        = sh_r;
    sel_nxt       = sel_r;
    a0_nxt        = a0_r;
    a1_nxt        = a1_r;
    clr_nxt       = clr_r;
    dy_nxt        = dy_r;
    ev_nxt        = 1'b0;
    evdx_nxt      = evdx_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r;
    acc_nxt       = acc_r;
    oacc_nxt      = oacc_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;

    req     = '0;
    in_tready = (state_r == S_IDLE);
    accept  = in_tvalid && in_tready;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    // position of an arriving pixel
    ay1 = 13'(row_r) + 13'd1;
    if (11'(col_r) >= effw) begin
      ax = '0;
      ay = (ay1 >= effh) ? '0 : ay1[YW-1:0];
    end else begin
      ax = col_r;
      ay = row_r;
    end
    if (13'(ay) >= effh) ay = '0;

    ar = in_tdata[RW-1:0];
    if (masken_r && in_tuser) ar = maskr_r;
    if (ar > RadiusSat) ar = RadiusSat;

    wl  = (ax >= XW'(32)) ? 4'((ax - XW'(32)) >> 6) : 4'd0;
    wl1 = 5'(wl) + 5'd1;

    dysq     = 12'(dy_r) * 12'(dy_r);
    srow     = y_r - YW'(dy_r);
    issue_ok = !hit_r && (dy_r <= DxW'(MaxRadius)) && (YW'(dy_r) <= y_r)
               && (dysq <= 12'(q_r));

    nx = 11'(x_r) + 11'd1;
    ny = 13'(y_r) + 13'd1;
    wword = x_r[6] ? q1 : q0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_nxt   = ax;
          y_nxt   = ay;
          r_nxt   = ar;
          lim_nxt = effw - 11'(ax);
          sh_nxt  = 7'(11'(ax) - {1'b0, wl, 6'b0} + 11'd32);
          sel_nxt = wl[0];
          a0_nxt  = wl[0] ? wl1[3:1] : wl[3:1];
          a1_nxt  = wl[0] ? wl[3:1] : wl1[3:1];
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        q_nxt   = QW'((20'(r_r) * 20'(r_r)) >> (2 * FracBits));
        clr_nxt = '0;
        dy_nxt  = '0;
        hit_nxt = 1'b0;
        state_nxt = (x_r == '0) ? S_CLR : S_SCAN;
      end
      S_CLR: begin
        req.wa  = {y_r[SlotW-1:0], clr_r};
        req.wd  = '0;
        req.we  = 2'b11;
        clr_nxt = clr_r + 3'd1;
        if (clr_r == 3'd7) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        req.ra0 = {srow[SlotW-1:0], a0_r};
        req.ra1 = {srow[SlotW-1:0], a1_r};
        if (ev_r && |(win & keep)) hit_nxt = 1'b1;
        if (issue_ok) begin
          ev_nxt   = 1'b1;
          evdx_nxt = dx_limit(q_r - QW'(dysq));
          dy_nxt   = dy_r + DxW'(1);
        end else if (!ev_r) begin
          if (!hit_r || r_r == '0) begin
            acc_nxt   = 1'b1;
            state_nxt = S_WRD;
          end else begin
            acc_nxt   = 1'b0;
            state_nxt = S_WWR;
          end
        end
      end
      S_WRD: begin
        req.ra0   = {y_r[SlotW-1:0], x_r[9:7]};
        req.ra1   = {y_r[SlotW-1:0], x_r[9:7]};
        state_nxt = S_WWR;
      end
      S_WWR: begin
        // also the hand-off step; a rejected pixel writes nothing
        // read address held so the word stays valid while the output is full
        req.ra0 = {y_r[SlotW-1:0], x_r[9:7]};
        req.ra1 = {y_r[SlotW-1:0], x_r[9:7]};
        if (!out_valid_r || out_tready) begin
          if (acc_r) begin
            req.wa = {y_r[SlotW-1:0], x_r[9:7]};
            req.wd = wword | (64'd1 << x_r[5:0]);
            req.we = x_r[6] ? 2'b10 : 2'b01;
          end
          out_valid_nxt = 1'b1;
          oacc_nxt = acc_r;
          ox_nxt = x_r;
          oy_nxt = y_r;
          if (nx >= effw) begin
            col_nxt = '0;
            row_nxt = (ny >= 13'(effh)) ? '0 : ny[YW-1:0];
          end else begin
            col_nxt = nx[XW-1:0];
            row_nxt = y_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      ev_r        <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      ev_r        <= ev_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    r_r    <= r_nxt;
    q_r    <= q_nxt;
    lim_r  <= lim_nxt;
    sh_r   <= sh_nxt;
    sel_r  <= sel_nxt;
    a0_r   <= a0_nxt;
    a1_r   <= a1_nxt;
    clr_r  <= clr_nxt;
    dy_r   <= dy_nxt;
    evdx_r <= evdx_nxt;
    acc_r  <= acc_nxt;
    oacc_r <= oacc_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b0, oy_r, ox_r};
  assign out_tuser  = oacc_r;

endmodule
